// ----- hw/rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

// invariant
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant failed");

`endif

// ----- hw/rtl/pds_pkg.sv -----
// ---------------------------------------------------------------------------
// pds_pkg
// Types, codes, constant tables and helpers for the pixel dither/scale block.
// ---------------------------------------------------------------------------
package pds_pkg;

    // column wrap; covers the whole 12-bit column field
    localparam int C_MAX_COLUMNS = 4096;

    // pixel formats (code 3 behaves as graymap)
    localparam logic [1:0] C_FMT_BITMAP = 2'd0;
    localparam logic [1:0] C_FMT_GRAY   = 2'd1;
    localparam logic [1:0] C_FMT_COLOR  = 2'd2;

    // inversion codes
    localparam logic [2:0] C_INV_NONE  = 3'd0;
    localparam logic [2:0] C_INV_CODE1 = 3'd1;
    localparam logic [2:0] C_INV_AUTO  = 3'd2;
    localparam logic [2:0] C_INV_CODE4 = 3'd3;
    localparam logic [2:0] C_INV_CODE5 = 3'd4;
    localparam logic [2:0] C_INV_CODE6 = 3'd5;
    localparam logic [2:0] C_INV_NEG5  = 3'd6;
    localparam logic [2:0] C_INV_NEG6  = 3'd7;

    // register indexes
    localparam logic [2:0] C_REG_FORMAT  = 3'd0;
    localparam logic [2:0] C_REG_INVERT  = 3'd1;
    localparam logic [2:0] C_REG_GAIN_R  = 3'd2;
    localparam logic [2:0] C_REG_GAIN_G  = 3'd3;
    localparam logic [2:0] C_REG_GAIN_B  = 3'd4;
    localparam logic [2:0] C_REG_DITH_R  = 3'd5;
    localparam logic [2:0] C_REG_DITH_G  = 3'd6;
    localparam logic [2:0] C_REG_DITH_B  = 3'd7;

    // reset values
    localparam logic [1:0]  C_FMT_RESET  = C_FMT_GRAY;
    localparam logic [23:0] C_GAIN_RESET = 24'd65793;

    // arithmetic constants
    localparam logic [23:0] C_FULL_Q16    = 24'hFF0000;  // 255.0 in Q16
    localparam logic [15:0] C_GRAY_THRESH = 16'd248;
    localparam logic [22:0] C_LUMA_THRESH = 23'd24800;
    localparam logic [11:0] C_RECIP5      = 12'd3277;    // ceil(2^14/5)
    localparam logic [17:0] C_RECIP25     = 18'd167773;  // ceil(2^22/25)
    localparam logic [11:0] C_GRAY_SCALE  = 12'd2621;    // floor(65536/25)
    localparam logic [4:0]  C_GRAY_REM    = 5'd11;       // 65536 mod 25

    // luma weights, Q16
    localparam logic [15:0] C_LUMA_W [3] = '{16'd19595, 16'd38470, 16'd7471};

    // ordered dither: entry (col%5)*5 + row%5 holds that index*8 mod 25
    localparam logic [4:0] C_DITHER [25] = '{
        5'd0,  5'd8,  5'd16, 5'd24, 5'd7,
        5'd15, 5'd23, 5'd6,  5'd14, 5'd22,
        5'd5,  5'd13, 5'd21, 5'd4,  5'd12,
        5'd20, 5'd3,  5'd11, 5'd19, 5'd2,
        5'd10, 5'd18, 5'd1,  5'd9,  5'd17
    };

    // configuration register file
    typedef struct packed {
        logic [1:0]       fmt;
        logic [2:0]       inv_code;
        logic [2:0][23:0] gain;
        logic [2:0][7:0]  dith;
    } t_cfg;

    // controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FIN,
        ST_LMUL,
        ST_LACC,
        ST_DONE
    } t_state;

    // controller -> datapath commands
    typedef struct packed {
        logic       load_in;
        logic       prep;
        logic       mul;
        logic       div;
        logic       fin;
        logic       lmul;
        logic       lacc;
        logic       load_out;
        logic [1:0] chan;
    } t_cmd;

    // datapath -> controller status
    typedef struct packed {
        logic out_free;
    } t_status;

    // x mod 5 for a 12-bit value, by reciprocal multiply
    function automatic logic [2:0] mod5(input logic [11:0] x);
        logic [23:0] p;
        logic [9:0]  q;
        logic [11:0] r;
        p = 24'(x) * 24'(C_RECIP5);
        q = p[23:14];
        r = x - 12'(12'(q) * 12'd5);
        return r[2:0];
    endfunction

    // floor(x/25), exact for x below 102400 (result fits 12 bits)
    function automatic logic [11:0] div25(input logic [16:0] x);
        logic [34:0] p;
        p = 35'(x) * 35'(C_RECIP25);
        return p[33:22];
    endfunction

    // dither numerator n (0..24) for a column/row pair
    function automatic logic [4:0] dither_n(input logic [11:0] col, input logic [11:0] row);
        logic [4:0] idx;
        idx = 5'(5'(mod5(col)) * 5'd5) + 5'(mod5(row));
        return C_DITHER[idx];
    endfunction

endpackage

// ----- hw/rtl/pnm_pixel_dither_scale_top.sv -----
// One pixel request in, one result out: each accepted pixel goes through
// prep, three channel passes of three steps, three luma multiply/accumulate
// steps and the output load, which waits while an untaken result holds the
// output register; then the block is ready again. The single shared 16x24
// multiplier serves the three sample*gain products and the three luma
// products in turn. The result sits in an output register, so the next
// pixel is taken while it waits. Configuration writes are taken every cycle
// and must only be made while no pixel is in flight.
// ---------------------------------------------------------------------------
// pnm_pixel_dither_scale_top
// Raw PNM pixel to 8-bit RGB + gray with gain, 5x5 ordered dither, invert.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pnm_pixel_dither_scale_top
    import pds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // pixel request stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // sample_a[15:0], sample_b[31:16], sample_c[47:32],
                                       // column[59:48], line_number[71:60]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // red_out[7:0], green_out[15:8], blue_out[23:16],
                                       // gray_out[31:24]
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    t_cfg    r_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fmt      <= C_FMT_RESET;
            r_cfg.inv_code <= C_INV_NONE;
            r_cfg.gain     <= {3{C_GAIN_RESET}};
            r_cfg.dith     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                C_REG_FORMAT: r_cfg.fmt      <= i_cfg_data[1:0];
                C_REG_INVERT: r_cfg.inv_code <= i_cfg_data[2:0];
                C_REG_GAIN_R: r_cfg.gain[0]  <= i_cfg_data;
                C_REG_GAIN_G: r_cfg.gain[1]  <= i_cfg_data;
                C_REG_GAIN_B: r_cfg.gain[2]  <= i_cfg_data;
                C_REG_DITH_R: r_cfg.dith[0]  <= i_cfg_data[7:0];
                C_REG_DITH_G: r_cfg.dith[1]  <= i_cfg_data[7:0];
                C_REG_DITH_B: r_cfg.dith[2]  <= i_cfg_data[7:0];
                default:      r_cfg          <= r_cfg;
            endcase
        end
    end

    pds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_status   (w_status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    pds_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cfg       (r_cfg),
        .i_in_data   (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_status    (w_status),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    // a pixel in flight blocks the next request
    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // result load never overwrites an untaken result
    `ASSERT_IMPLY(a_load_when_free, i_clk, i_rst_n, w_cmd.load_out, !m_axis_tvalid || m_axis_tready)

    // at most one datapath step per cycle
    `ASSERT_ALWAYS(a_one_step, i_clk, i_rst_n, $onehot0({w_cmd.load_in, w_cmd.prep, w_cmd.mul, w_cmd.div, w_cmd.fin, w_cmd.lmul, w_cmd.lacc, w_cmd.load_out}))

endmodule

// ----- hw/rtl/pds_ctrl.sv -----
// ---------------------------------------------------------------------------
// pds_ctrl
// Sequencer: walks one pixel through prep, three channel passes, three luma
// multiply/accumulate steps and the output load.
// ---------------------------------------------------------------------------
module pds_ctrl
    import pds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_chan,  n_chan;
    logic       w_last;

    assign w_last = (r_chan == 2'd2);

    // state and channel counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_chan  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_chan  <= n_chan;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_chan  = r_chan;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = ST_MUL;
                n_chan  = 2'd0;
            end
            ST_MUL:  n_state = ST_DIV;
            ST_DIV:  n_state = ST_FIN;
            ST_FIN: begin
                if (w_last) begin
                    n_state = ST_LMUL;
                    n_chan  = 2'd0;
                end else begin
                    n_state = ST_MUL;
                    n_chan  = r_chan + 2'd1;
                end
            end
            ST_LMUL: n_state = ST_LACC;
            ST_LACC: begin
                if (w_last) begin
                    n_state = ST_DONE;
                    n_chan  = 2'd0;
                end else begin
                    n_state = ST_LMUL;
                    n_chan  = r_chan + 2'd1;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.chan = r_chan;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_in_valid;
            end
            ST_PREP: o_cmd.prep = 1'b1;
            ST_MUL:  o_cmd.mul  = 1'b1;
            ST_DIV:  o_cmd.div  = 1'b1;
            ST_FIN:  o_cmd.fin  = 1'b1;
            ST_LMUL: o_cmd.lmul = 1'b1;
            ST_LACC: o_cmd.lacc = 1'b1;
            ST_DONE: o_cmd.load_out = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ----- hw/rtl/pds_datapath.sv -----
// ---------------------------------------------------------------------------
// pds_datapath
// Pixel registers, invert decision, one shared 16x24 multiplier, dither
// term, clamp/invert, luma accumulator and the output register.
// ---------------------------------------------------------------------------
module pds_datapath
    import pds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  t_cfg        i_cfg,
    input  logic [71:0] i_in_data,   // sample_a, sample_b, sample_c, column, line_number
    input  logic        i_out_ready,
    output t_status     o_status,
    output logic        o_out_valid,
    output logic [31:0] o_out_data   // red_out, green_out, blue_out, gray_out
);

    // pixel registers
    logic [2:0][15:0] r_s;
    logic [11:0]      r_col;
    logic [11:0]      r_line;
    logic [4:0]       r_n;
    logic             r_inv;
    logic             r_row_inv;

    // arithmetic registers
    logic [39:0]      r_prod;
    logic [12:0]      r_m;
    logic [11:0]      r_q;
    logic [23:0]      r_base;
    logic [2:0][23:0] r_v;
    logic [41:0]      r_acc;

    // output register
    logic             r_out_valid;
    logic [31:0]      r_out;

    logic             w_gray;
    logic             w_bit;
    logic             w_start;
    logic [22:0]      w_luma_sum;
    logic             n_inv;
    logic             n_row_inv;

    logic [15:0]      w_s_sel;
    logic [23:0]      w_gain_sel;
    logic [7:0]       w_dith_sel;
    logic [23:0]      w_v_sel;
    logic [15:0]      w_w_sel;
    logic [15:0]      w_mul_a;
    logic [23:0]      w_mul_b;

    logic [16:0]      w_x;
    logic [24:0]      w_term;
    logic [40:0]      w_sum;
    logic [23:0]      w_clip;
    logic [23:0]      w_v;

    logic [41:0]      w_acc_rnd;
    logic [9:0]       w_luma_q;
    logic [7:0]       w_luma8;
    logic [7:0]       w_bit8;
    logic [7:0]       w_r8;
    logic [7:0]       w_g8;
    logic [7:0]       w_b8;
    logic [31:0]      w_out;

    // round a clamped Q16 value to 8 bits
    function automatic logic [7:0] round8(input logic [23:0] v);
        logic [23:0] t;
        t = v + 24'h008000;
        return t[23:16];
    endfunction

    assign w_gray  = (i_cfg.fmt != C_FMT_BITMAP) && (i_cfg.fmt != C_FMT_COLOR);
    assign w_bit   = (r_s[0] != 16'd0);
    assign w_start = (r_col == 12'd0);
    assign w_luma_sum = 23'(r_s[0]) * 23'd30 + 23'(r_s[1]) * 23'd59
                      + 23'(r_s[2]) * 23'd11;

    // invert decision and row state update
    always_comb begin
        n_row_inv = r_row_inv;
        n_inv     = 1'b0;
        case (i_cfg.fmt)
            C_FMT_BITMAP: begin
                if (i_cfg.inv_code == C_INV_AUTO) begin
                    if (w_start) begin
                        n_row_inv = !w_bit;
                        n_inv     = 1'b1;
                    end else begin
                        n_inv     = r_row_inv;
                    end
                end else begin
                    n_inv = i_cfg.inv_code inside {C_INV_CODE1, C_INV_CODE4,
                                                   C_INV_NEG5, C_INV_NEG6};
                end
            end
            C_FMT_COLOR: begin
                if (i_cfg.inv_code == C_INV_AUTO) begin
                    if (w_start) begin
                        n_row_inv = (w_luma_sum < C_LUMA_THRESH);
                    end
                    n_inv = n_row_inv;
                end else begin
                    n_inv = i_cfg.inv_code inside {C_INV_CODE1, C_INV_CODE6, C_INV_NEG5};
                end
            end
            default: begin
                if (i_cfg.inv_code == C_INV_AUTO) begin
                    if (w_start) begin
                        n_row_inv = (r_s[0] < C_GRAY_THRESH);
                    end
                    n_inv = n_row_inv;
                end else begin
                    n_inv = i_cfg.inv_code inside {C_INV_CODE1, C_INV_CODE5, C_INV_NEG6};
                end
            end
        endcase
    end

    // per-channel operand select
    always_comb begin
        case (i_cmd.chan)
            2'd1: begin
                w_s_sel    = r_s[1];
                w_gain_sel = i_cfg.gain[1];
                w_dith_sel = i_cfg.dith[1];
                w_v_sel    = r_v[1];
                w_w_sel    = C_LUMA_W[1];
            end
            2'd2: begin
                w_s_sel    = r_s[2];
                w_gain_sel = i_cfg.gain[2];
                w_dith_sel = i_cfg.dith[2];
                w_v_sel    = r_v[2];
                w_w_sel    = C_LUMA_W[2];
            end
            default: begin
                w_s_sel    = r_s[0];
                w_gain_sel = i_cfg.gain[0];
                w_dith_sel = i_cfg.dith[0];
                w_v_sel    = r_v[0];
                w_w_sel    = C_LUMA_W[0];
            end
        endcase
    end

    // shared multiplier operands: sample*gain or weight*value
    assign w_mul_a = i_cmd.lmul ? w_w_sel : w_s_sel;
    assign w_mul_b = i_cmd.lmul ? w_v_sel : w_gain_sel;

    // gray term is floor(m*65536/25) = m*2621 + floor(11m/25)
    assign w_x = w_gray ? 17'(17'(r_m) * 17'(C_GRAY_REM)) : 17'(r_m);

    // add term, clamp at 255.0, invert
    assign w_term = w_gray ? 25'(25'(r_base) + 25'(r_q)) : {1'b0, r_q[7:0], 16'h0000};
    assign w_sum  = 41'(r_prod) + 41'(w_term);
    assign w_clip = (w_sum > 41'(C_FULL_Q16)) ? C_FULL_Q16 : w_sum[23:0];
    assign w_v    = r_inv ? (C_FULL_Q16 - w_clip) : w_clip;

    // luma rounding at bit 32
    assign w_acc_rnd = r_acc + (42'd1 << 31);
    assign w_luma_q  = w_acc_rnd[41:32];
    assign w_luma8   = (w_luma_q > 10'd255) ? 8'd255 : w_luma_q[7:0];

    assign w_bit8 = (w_bit ^ r_inv) ? 8'd255 : 8'd0;
    assign w_r8   = round8(r_v[0]);
    assign w_g8   = round8(r_v[1]);
    assign w_b8   = round8(r_v[2]);

    // result by format
    always_comb begin
        case (i_cfg.fmt)
            C_FMT_BITMAP: w_out = {w_bit8, w_bit8, w_bit8, w_bit8};
            C_FMT_COLOR:  w_out = {w_luma8, w_b8, w_g8, w_r8};
            default:      w_out = {w_r8, w_r8, w_r8, w_r8};
        endcase
    end

    // pixel capture and arithmetic steps
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_s[0] <= i_in_data[15:0];
            r_s[1] <= i_in_data[31:16];
            r_s[2] <= i_in_data[47:32];
            r_col  <= 12'(32'(i_in_data[59:48]) % C_MAX_COLUMNS);
            r_line <= i_in_data[71:60];
        end
        if (i_cmd.prep) begin
            r_n   <= dither_n(r_col, r_line);
            r_inv <= n_inv;
            r_acc <= '0;
        end
        if (i_cmd.mul || i_cmd.lmul) begin
            r_prod <= 40'(w_mul_a) * 40'(w_mul_b);
        end
        if (i_cmd.mul) begin
            r_m <= 13'(w_dith_sel) * 13'(r_n);
        end
        if (i_cmd.div) begin
            r_q    <= div25(w_x);
            r_base <= 24'(r_m) * 24'(C_GRAY_SCALE);
        end
        if (i_cmd.fin) begin
            case (i_cmd.chan)
                2'd1:    r_v[1] <= w_v;
                2'd2:    r_v[2] <= w_v;
                default: r_v[0] <= w_v;
            endcase
        end
        if (i_cmd.lacc) begin
            r_acc <= r_acc + 42'(r_prod);
        end
        if (i_cmd.load_out) begin
            r_out <= w_out;
        end
    end

    // row state and output handshake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_inv   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.prep) begin
                r_row_inv <= n_row_inv;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;

endmodule

// ----- tb/tb.sv -----
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the PNM pixel dither/scale block. A directed table
// covers reset values, extremes, the three formats and auto invert. Random
// phases follow, each with a full register rewrite and bursty pixel traffic.
// Every result is checked against the table or a predictor in the bench.
// ---------------------------------------------------------------------------
module tb;
    import pds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // format code 3 is taken as graymap
    localparam logic [1:0] FMT_GRAY_ALIAS = 2'd3;
    localparam int         PIXEL_TARGET   = 1750;
    localparam int         CYCLE_LIMIT    = 750000;
    localparam int         DRAIN_LIMIT    = 20000;
    localparam int         SETTLE_CYCLES  = 24;

    // pixel request, sample_a in the low bits
    typedef struct packed {
        logic [11:0] line_number;
        logic [11:0] column;
        logic [15:0] sample_c;
        logic [15:0] sample_b;
        logic [15:0] sample_a;
    } pixel_t;

    // result, red in the low byte
    typedef struct packed {
        logic [7:0] gray;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgbg_t;

    // one row of the directed table: register write or pixel
    typedef struct {
        logic        is_cfg;
        logic [2:0]  reg_idx;
        logic [23:0] reg_val;
        pixel_t      px;
        logic        has_exp;
        logic [31:0] exp_val;
    } step_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index   = C_REG_FORMAT;
    logic [23:0] i_cfg_data    = '0;

    // predictor copy of the register file and row state
    logic [1:0]  cur_fmt;
    logic [2:0]  cur_inv;
    logic [23:0] cur_gain [3];
    logic [7:0]  cur_dith [3];
    logic        row_inv_q;

    rgbg_t       pending_rgbg [$];
    step_t       directed [$];
    logic [2:0]  wr_idx_q [$];
    logic [23:0] wr_val_q [$];

    int          n_fail     = 0;
    int          cycle_cnt  = 0;
    int          rx_mode    = 0;
    int          rx_hold    = 0;
    int          pix_sent   = 0;
    int          burst_left = 0;
    logic [11:0] col_r      = '0;
    logic [11:0] line_r     = '0;
    int          row_len    = 4;

    pnm_pixel_dither_scale_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // clamp at full scale, then optional inversion, all in Q16
    function automatic logic [63:0] clamp_invert(input logic [63:0] v, input logic inv);
        logic [63:0] full;
        full = 64'(C_FULL_Q16);
        if (v > full) v = full;
        if (inv) v = full - v;
        return v;
    endfunction

    function automatic logic [7:0] round_q16(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'h8000) >> 16;
        return (r > 64'd255) ? 8'hFF : r[7:0];
    endfunction

    // expected RGB + gray for one pixel; updates the auto-invert row state
    function automatic rgbg_t convert_pixel(input pixel_t px);
        logic [63:0] smp [3];
        logic [63:0] val [3];
        logic [63:0] luma;
        logic [7:0]  chan [4];
        logic [11:0] col;
        int unsigned n;
        logic        inv;
        logic        lit;
        logic        start;
        int          k;
        smp[0] = 64'(px.sample_a);
        smp[1] = 64'(px.sample_b);
        smp[2] = 64'(px.sample_c);
        col    = 12'(px.column % C_MAX_COLUMNS);
        n      = ((int'(col % 5) * 5 + int'(px.line_number % 5)) * 8) % 25;
        start  = (col == 12'd0);
        inv    = 1'b0;
        case (cur_fmt)
            C_FMT_BITMAP: begin
                lit = (px.sample_a != 16'd0);
                if (cur_inv == C_INV_AUTO) begin
                    // column 0 pixel always flips; row follows the bit
                    if (start) begin
                        row_inv_q = ~lit;
                        inv = 1'b1;
                    end else begin
                        inv = row_inv_q;
                    end
                end else begin
                    inv = (cur_inv == C_INV_CODE1) || (cur_inv == C_INV_CODE4) ||
                          (cur_inv == C_INV_NEG5)  || (cur_inv == C_INV_NEG6);
                end
                if (inv) lit = ~lit;
                for (k = 0; k < 4; k++) chan[k] = lit ? 8'hFF : 8'h00;
            end
            C_FMT_COLOR: begin
                if (cur_inv == C_INV_AUTO) begin
                    if (start)
                        row_inv_q = (smp[0] * 30 + smp[1] * 59 + smp[2] * 11) <
                                    64'(C_LUMA_THRESH);
                    inv = row_inv_q;
                end else begin
                    inv = (cur_inv == C_INV_CODE1) || (cur_inv == C_INV_CODE6) ||
                          (cur_inv == C_INV_NEG5);
                end
                // integer dither term per channel, then luma on Q16 values
                luma = '0;
                for (k = 0; k < 3; k++) begin
                    val[k] = clamp_invert(smp[k] * 64'(cur_gain[k]) +
                                          (((64'(cur_dith[k]) * 64'(n)) / 64'd25) << 16),
                                          inv);
                    luma += 64'(C_LUMA_W[k]) * val[k];
                    chan[k] = round_q16(val[k]);
                end
                luma = (luma + 64'h8000_0000) >> 32;
                chan[3] = (luma > 64'd255) ? 8'hFF : luma[7:0];
            end
            default: begin
                if (cur_inv == C_INV_AUTO) begin
                    if (start) row_inv_q = (px.sample_a < C_GRAY_THRESH);
                    inv = row_inv_q;
                end else begin
                    inv = (cur_inv == C_INV_CODE1) || (cur_inv == C_INV_CODE5) ||
                          (cur_inv == C_INV_NEG6);
                end
                // gray keeps the dither fraction
                val[0] = clamp_invert(smp[0] * 64'(cur_gain[0]) +
                                      (64'(cur_dith[0]) * 64'(n) * 64'd65536) / 64'd25,
                                      inv);
                for (k = 0; k < 4; k++) chan[k] = round_q16(val[0]);
            end
        endcase
        return {chan[3], chan[2], chan[1], chan[0]};
    endfunction

    task automatic add_cfg(input logic [2:0] idx, input logic [23:0] val);
        step_t s;
        s = '{default: '0};
        s.is_cfg  = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        directed.push_back(s);
    endtask

    task automatic add_px(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c,
                          input logic [11:0] col, input logic [11:0] line,
                          input logic has, input logic [31:0] exp_val);
        step_t s;
        s = '{default: '0};
        s.px      = '{line_number: line, column: col, sample_c: c, sample_b: b,
                      sample_a: a};
        s.has_exp = has;
        s.exp_val = exp_val;
        directed.push_back(s);
    endtask

    // drop valid and let every pending result drain before a register write
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_rgbg.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // write the queued registers back to back, valid held high between them
    task automatic write_regs();
        while (wr_idx_q.size() != 0) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= wr_idx_q[0];
            i_cfg_data  <= wr_val_q[0];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (wr_idx_q[0])
                C_REG_FORMAT: cur_fmt     = wr_val_q[0][1:0];
                C_REG_INVERT: cur_inv     = wr_val_q[0][2:0];
                C_REG_GAIN_R: cur_gain[0] = wr_val_q[0];
                C_REG_GAIN_G: cur_gain[1] = wr_val_q[0];
                C_REG_GAIN_B: cur_gain[2] = wr_val_q[0];
                C_REG_DITH_R: cur_dith[0] = wr_val_q[0][7:0];
                C_REG_DITH_G: cur_dith[1] = wr_val_q[0][7:0];
                C_REG_DITH_B: cur_dith[2] = wr_val_q[0][7:0];
                default: ;
            endcase
            void'(wr_idx_q.pop_front());
            void'(wr_val_q.pop_front());
        end
        i_cfg_valid <= 1'b0;
    endtask

    // one pixel request after an optional gap; expectation queued on accept
    task automatic send_pixel(input pixel_t px, input int gap,
                              input logic has, input logic [31:0] exp_val);
        rgbg_t pred;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pred = convert_pixel(px);
        pending_rgbg.push_back(has ? rgbg_t'(exp_val) : pred);
        pix_sent++;
    endtask

    function automatic logic [15:0] pick_sample();
        logic [15:0] edges [5];
        edges = '{16'd0, 16'hFFFF, 16'd255, 16'd248, 16'd247};
        case ($urandom_range(0, 4))
            0: return 16'($urandom_range(0, 255));
            1: return 16'($urandom_range(200, 300));
            2: return 16'($urandom);
            3: return edges[$urandom_range(0, 4)];
            default: return 16'($urandom_range(0, 600));
        endcase
    endfunction

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return C_GAIN_RESET;
            3: return 24'd256;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [23:0] pick_dither();
        case ($urandom_range(0, 3))
            0: return 24'd0;
            1: return 24'd255;
            default: return 24'($urandom_range(0, 255));
        endcase
    endfunction

    // rows of random length; column 0 restarts the auto-invert decision
    function automatic pixel_t next_pixel();
        pixel_t px;
        if (col_r >= 12'(row_len) || $urandom_range(0, 49) == 0) begin
            col_r   = '0;
            line_r  = ($urandom_range(0, 7) == 0) ? 12'($urandom) : line_r + 12'd1;
            row_len = $urandom_range(1, 16);
        end else if ($urandom_range(0, 39) == 0) begin
            col_r = 12'($urandom);
        end else begin
            col_r = col_r + 12'd1;
        end
        px.sample_a    = pick_sample();
        px.sample_b    = pick_sample();
        px.sample_c    = pick_sample();
        px.column      = col_r;
        px.line_number = line_r;
        return px;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        rgbg_t got;
        rgbg_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_rgbg.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                n_fail++;
            end else begin
                want = pending_rgbg.pop_front();
                if (got.red != want.red) begin
                    $display("%0t: red exp %0d got %0d", $time, want.red, got.red);
                    n_fail++;
                end
                if (got.green != want.green) begin
                    $display("%0t: green exp %0d got %0d", $time, want.green, got.green);
                    n_fail++;
                end
                if (got.blue != want.blue) begin
                    $display("%0t: blue exp %0d got %0d", $time, want.blue, got.blue);
                    n_fail++;
                end
                if (got.gray != want.gray) begin
                    $display("%0t: gray exp %0d got %0d", $time, want.gray, got.gray);
                    n_fail++;
                end
            end
        end
    end

    // receiver back-pressure, pattern chosen per phase
    always @(posedge i_clk) begin
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            2: m_axis_tready <= (cycle_cnt % 9) >= 4;
            default: begin
                if (rx_hold > 0) begin
                    m_axis_tready <= 1'b0;
                    rx_hold <= rx_hold - 1;
                end else begin
                    m_axis_tready <= 1'b1;
                    if ($urandom_range(0, 5) == 0) rx_hold <= $urandom_range(5, 40);
                end
            end
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        pixel_t px;
        int     phase;
        int     n_items;
        int     gap;
        int     no_idle;
        int     drain;

        cur_fmt   = C_FMT_RESET;
        cur_inv   = C_INV_NONE;
        cur_gain  = '{C_GAIN_RESET, C_GAIN_RESET, C_GAIN_RESET};
        cur_dith  = '{8'd0, 8'd0, 8'd0};
        row_inv_q = 1'b0;

        // reset-state graymap: zero, full scale, clamp at the top corner
        add_px(16'd0,     16'd0,     16'd0,     12'd0,    12'd0,    1, 32'h0000_0000);
        add_px(16'd255,   16'hFFFF,  16'hFFFF,  12'd1,    12'd0,    1, 32'hFFFF_FFFF);
        add_px(16'hFFFF,  16'd0,     16'd0,     12'd4095, 12'd4095, 1, 32'hFFFF_FFFF);
        add_px(16'd128,   16'd0,     16'd0,     12'd2,    12'd3,    0, '0);
        add_cfg(C_REG_INVERT, 24'(C_INV_CODE1));
        add_px(16'd0,     16'd0,     16'd0,     12'd1,    12'd1,    1, 32'hFFFF_FFFF);
        add_px(16'd255,   16'd0,     16'd0,     12'd2,    12'd1,    1, 32'h0000_0000);
        // code4 leaves gray alone
        add_cfg(C_REG_INVERT, 24'(C_INV_CODE4));
        add_px(16'd0,     16'd0,     16'd0,     12'd3,    12'd1,    1, 32'h0000_0000);
        // bitmap: any nonzero sample is a set bit
        add_cfg(C_REG_FORMAT, 24'(C_FMT_BITMAP));
        add_cfg(C_REG_INVERT, 24'(C_INV_NONE));
        add_px(16'd0,     16'd0,     16'd0,     12'd0,    12'd0,    1, 32'h0000_0000);
        add_px(16'd1,     16'd0,     16'd0,     12'd1,    12'd0,    1, 32'hFFFF_FFFF);
        add_px(16'h8000,  16'd0,     16'd0,     12'd2,    12'd0,    1, 32'hFFFF_FFFF);
        // bitmap auto invert: column 0 always flips, row follows the bit
        add_cfg(C_REG_INVERT, 24'(C_INV_AUTO));
        add_px(16'd1,     16'd0,     16'd0,     12'd0,    12'd1,    1, 32'h0000_0000);
        add_px(16'd1,     16'd0,     16'd0,     12'd1,    12'd1,    1, 32'hFFFF_FFFF);
        add_px(16'd0,     16'd0,     16'd0,     12'd0,    12'd2,    1, 32'hFFFF_FFFF);
        add_px(16'd0,     16'd0,     16'd0,     12'd5,    12'd2,    1, 32'hFFFF_FFFF);
        // colour with max gains and max dither
        add_cfg(C_REG_FORMAT, 24'(C_FMT_COLOR));
        add_cfg(C_REG_INVERT, 24'(C_INV_NONE));
        add_cfg(C_REG_GAIN_R, 24'hFFFFFF);
        add_cfg(C_REG_GAIN_G, 24'hFFFFFF);
        add_cfg(C_REG_GAIN_B, 24'hFFFFFF);
        add_cfg(C_REG_DITH_R, 24'd255);
        add_cfg(C_REG_DITH_G, 24'd255);
        add_cfg(C_REG_DITH_B, 24'd255);
        add_px(16'hFFFF,  16'hFFFF,  16'hFFFF,  12'd3,    12'd4,    1, 32'hFFFF_FFFF);
        add_px(16'd0,     16'd0,     16'd0,     12'd1,    12'd2,    0, '0);
        add_px(16'd100,   16'd200,   16'd50,    12'd4,    12'd4,    0, '0);
        // zero gains: only the dither term is left, and it is zero at (0,0)
        add_cfg(C_REG_GAIN_R, 24'd0);
        add_cfg(C_REG_GAIN_G, 24'd0);
        add_cfg(C_REG_GAIN_B, 24'd0);
        add_px(16'hFFFF,  16'hFFFF,  16'hFFFF,  12'd0,    12'd0,    1, 32'h0000_0000);
        add_cfg(C_REG_INVERT, 24'(C_INV_AUTO));
        add_px(16'd0,     16'd0,     16'd0,     12'd0,    12'd3,    0, '0);
        add_px(16'd300,   16'd300,   16'd300,   12'd1,    12'd3,    0, '0);
        // format code 3 acts as graymap; auto threshold on both sides
        add_cfg(C_REG_FORMAT, 24'(FMT_GRAY_ALIAS));
        add_cfg(C_REG_GAIN_R, C_GAIN_RESET);
        add_px(16'd247,   16'd0,     16'd0,     12'd0,    12'd5,    0, '0);
        add_px(16'd248,   16'd0,     16'd0,     12'd0,    12'd6,    0, '0);
        add_px(16'd100,   16'd0,     16'd0,     12'd3,    12'd7,    0, '0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed[i]) begin
            if (directed[i].is_cfg) begin
                wr_idx_q.push_back(directed[i].reg_idx);
                wr_val_q.push_back(directed[i].reg_val);
            end else begin
                if (wr_idx_q.size() != 0) begin
                    wait_idle();
                    write_regs();
                end
                send_pixel(directed[i].px, 0, directed[i].has_exp, directed[i].exp_val);
            end
        end

        // random phases, full register rewrite at each boundary
        phase = 0;
        while (pix_sent < PIXEL_TARGET + directed.size() / 2) begin
            wait_idle();
            wr_idx_q = '{C_REG_FORMAT, C_REG_INVERT, C_REG_GAIN_R, C_REG_GAIN_G,
                         C_REG_GAIN_B, C_REG_DITH_R, C_REG_DITH_G, C_REG_DITH_B};
            if (phase == 0) begin
                wr_val_q = '{24'(C_FMT_COLOR), 24'(C_INV_NEG6), 24'hFFFFFF, 24'hFFFFFF,
                             24'hFFFFFF, 24'd255, 24'd255, 24'd255};
            end else if (phase == 1) begin
                wr_val_q = '{24'(C_FMT_BITMAP), 24'(C_INV_NONE), 24'd0, 24'd0,
                             24'd0, 24'd0, 24'd0, 24'd0};
            end else begin
                wr_val_q = '{24'($urandom_range(0, 3)),
                             ($urandom_range(0, 9) < 4) ? 24'(C_INV_AUTO)
                                                         : 24'($urandom_range(0, 7)),
                             pick_gain(), pick_gain(), pick_gain(),
                             pick_dither(), pick_dither(), pick_dither()};
            end
            write_regs();
            rx_mode = $urandom_range(0, 3);
            no_idle = ($urandom_range(0, 3) == 0);
            n_items = $urandom_range(30, 150);
            burst_left = 0;
            repeat (n_items) begin
                gap = 0;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 30);
                    if (!no_idle) gap = $urandom_range(1, 20);
                end
                burst_left--;
                px = next_pixel();
                send_pixel(px, gap, 1'b0, '0);
            end
            phase++;
        end
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray results
        drain = 0;
        while (pending_rgbg.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (40) @(posedge i_clk);
        if (pending_rgbg.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_rgbg.size());
            n_fail++;
        end

        if (n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- pnm_pixel_dither_scale_top.f -----
+incdir+hw/rtl
hw/rtl/pds_pkg.sv
hw/rtl/pds_ctrl.sv
hw/rtl/pds_datapath.sv
hw/rtl/pnm_pixel_dither_scale_top.sv
tb/tb.sv
